/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FIELD_W       = 32;  // width of each data field on the ports
  localparam int unsigned CMD_W         = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_LT       = 4'd4,
    CMD_LE       = 4'd5,
    CMD_GT       = 4'd6,
    CMD_GE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_TO_INT   = 4'd14,
    CMD_FROM_INT = 4'd15
  } cmd_e;

  // per-beat status carried down the pipe
  typedef struct packed {
    logic cmp;     // comparison holds
    logic of;      // saturated
    logic dz;      // divide by zero
    logic is_div;  // divider result still to be finished
    logic presat;  // quotient known to exceed the word before any step
    logic neg;     // sign of the divider result
  } flags_t;

endpackage

/* rtl/fpa_div_stage.sv */
// ----------------------------------------------------------------------------
// fpa_div_stage
// One pipeline stage of the restoring divider: two quotient bits per beat.
// ----------------------------------------------------------------------------
module fpa_div_stage #(
  parameter int unsigned OPW  = 32,
  parameter int unsigned BASE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  input  logic [OPW-1:0]     r_i,
  input  fpa_pkg::flags_t    fl_i,
  input  logic [OPW-1:0]     d_i,
  input  logic [OPW-1:0]     rem_i,
  input  logic [OPW-1:0]     q_i,
  input  logic [OPW-1:0]     low_i,
  output logic [OPW-1:0]     r_o,
  output fpa_pkg::flags_t    fl_o,
  output logic [OPW-1:0]     d_o,
  output logic [OPW-1:0]     rem_o,
  output logic [OPW-1:0]     q_o,
  output logic [OPW-1:0]     low_o
);

  localparam int unsigned STEPS = 2;

  logic                  v_q;
  logic                  en;
  logic [OPW-1:0]        r_q, d_q, rem_q, q_q, low_q;
  fpa_pkg::flags_t       fl_q;
  logic [OPW-1:0]        rem_d, q_d, low_d;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  always_comb begin
    logic [OPW:0] trial;
    rem_d = rem_i;
    q_d   = q_i;
    low_d = low_i;
    trial = '0;
    for (int j = 0; j < STEPS; j++) begin
      if (BASE + j < OPW) begin
        trial = {rem_d, low_d[OPW-1]} - {1'b0, d_i};
        if (!trial[OPW]) begin
          rem_d = trial[OPW-1:0];
          q_d   = {q_d[OPW-2:0], 1'b1};
        end else begin
          rem_d = {rem_d[OPW-2:0], low_d[OPW-1]};
          q_d   = {q_d[OPW-2:0], 1'b0};
        end
        low_d = {low_d[OPW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q   <= r_i;
      fl_q  <= fl_i;
      d_q   <= d_i;
      rem_q <= rem_d;
      q_q   <= q_d;
      low_q <= low_d;
    end
  end

  assign valid_o = v_q;
  assign r_o     = r_q;
  assign fl_o    = fl_q;
  assign d_o     = d_q;
  assign rem_o   = rem_q;
  assign q_o     = q_q;
  assign low_o   = low_q;

endmodule

/* rtl/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed fixed-point ALU: add, sub, mul, div, compares, min/max,
// raw inc/dec and integer conversions, with rounding and saturation.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                               tuser
//  s_axis    in   operand_a[31:0], operand_b[31:0]                 cmd[3:0]
//  m_axis    out  result_value[31:0], compare_true, overflow_flag, -
//                 divide_by_zero, 5 zero bits
//
//  One beat enters per cycle while the pipe is not stalled. The depth is
//  set by the restoring divider, which retires two quotient bits per
//  stage; every command rides the same pipe so order is kept.
//  Each stage holds its beat while the next one is full and stalled, so
//  bubbles collapse and a stall loses or repeats nothing.
//  Reset clears the valid bits only.
//
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  s_axis_tuser,   // cmd[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result[31:0], cmp[32], of[33], dz[34], zero
);

  // working width: fields are 32 bits, so narrower of the two
  localparam int unsigned OPW = (WORD_BITS > fpa_pkg::FIELD_W) ? fpa_pkg::FIELD_W : WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NW  = OPW + F;         // scaled dividend width
  localparam int unsigned MW  = 2 * OPW + F;     // magnitude width for saturation
  localparam int unsigned SW  = OPW + 2;         // add/sub width
  localparam int unsigned DS  = (OPW + 1) / 2;   // divider stages

  localparam logic [OPW-1:0] WMAX_W = {1'b0, {(OPW-1){1'b1}}};
  localparam logic [OPW-1:0] WMIN_W = {1'b1, {(OPW-1){1'b0}}};

  // magnitude plus sign -> {overflow, saturated word}
  function automatic logic [OPW:0] sat_mag(input logic [MW-1:0] m, input logic neg);
    logic [MW-1:0]  nm;
    logic           of;
    logic [OPW-1:0] r;
    nm = MW'(0) - m;
    if (neg) begin
      of = m > MW'(WMIN_W);
      r  = of ? WMIN_W : nm[OPW-1:0];
    end else begin
      of = m > MW'(WMAX_W);
      r  = of ? WMAX_W : m[OPW-1:0];
    end
    return {of, r};
  endfunction

  // ---- stage 1: input register ----
  logic                s1_v_q, en1, en2;
  fpa_pkg::cmd_e       s1_cmd_q;
  logic [OPW-1:0]      s1_a_q, s1_b_q;

  assign en1           = !s1_v_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_cmd_q <= fpa_pkg::cmd_e'(s_axis_tuser);
      s1_a_q   <= s_axis_tdata[OPW-1:0];
      s1_b_q   <= s_axis_tdata[32 +: OPW];
    end
  end

  // ---- stage 2: decode, add/compare/convert, multiply, divider setup ----
  logic                 s2_v_q, en3;
  logic [OPW-1:0]       s2_r_q, s2_r_d;
  fpa_pkg::flags_t      s2_fl_q, s2_fl_d;
  logic                 s2_mul_q, s2_mul_d;
  logic [2*OPW-1:0]     s2_prod_q, s2_prod_d;
  logic [OPW-1:0]       s2_d_q, s2_d_d, s2_rem_q, s2_rem_d, s2_low_q, s2_low_d;

  assign en2 = !s2_v_q || en3;

  always_comb begin
    logic signed [OPW-1:0] a_s, b_s;
    logic [OPW-1:0]        ma, mb, ti;
    logic [NW-1:0]         n, hi;
    logic [SW-1:0]         ax, y, sum;
    logic [OPW:0]          sm;
    a_s = signed'(s1_a_q);
    b_s = signed'(s1_b_q);
    ma  = a_s[OPW-1] ? (OPW'(0) - s1_a_q) : s1_a_q;
    mb  = b_s[OPW-1] ? (OPW'(0) - s1_b_q) : s1_b_q;
    n   = {ma, {F{1'b0}}};
    hi  = n >> OPW;
    ax  = SW'(a_s);
    case (s1_cmd_q)
      fpa_pkg::CMD_SUB: y = SW'(0) - SW'(b_s);
      fpa_pkg::CMD_INC: y = SW'(1);
      fpa_pkg::CMD_DEC: y = {SW{1'b1}};
      default:          y = SW'(b_s);
    endcase
    sum = ax + y;
    ti  = OPW'(ma >> F);
    sm  = sat_mag(MW'(ma) << F, a_s[OPW-1]);
    // full signed product, sign-extended operands
    s2_prod_d = (2*OPW)'(a_s) * (2*OPW)'(b_s);

    s2_r_d   = '0;
    s2_fl_d  = '0;
    s2_mul_d = 1'b0;
    s2_d_d   = mb;
    s2_rem_d = hi[OPW-1:0];
    s2_low_d = n[OPW-1:0];
    unique case (s1_cmd_q)
      fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC: begin
        s2_fl_d.of = (sum[SW-1:OPW-1] != {3{1'b0}}) && (sum[SW-1:OPW-1] != {3{1'b1}});
        s2_r_d     = s2_fl_d.of ? (sum[SW-1] ? WMIN_W : WMAX_W) : sum[OPW-1:0];
      end
      fpa_pkg::CMD_MUL: s2_mul_d = 1'b1;
      fpa_pkg::CMD_DIV: begin
        if (mb == '0) begin
          s2_fl_d.dz = 1'b1;
          s2_r_d     = a_s[OPW-1] ? WMIN_W : WMAX_W;
        end else begin
          s2_fl_d.is_div = 1'b1;
          s2_fl_d.presat = hi >= NW'(mb);
          s2_fl_d.neg    = a_s[OPW-1] ^ b_s[OPW-1];
        end
      end
      fpa_pkg::CMD_LT:     s2_fl_d.cmp = a_s < b_s;
      fpa_pkg::CMD_LE:     s2_fl_d.cmp = a_s <= b_s;
      fpa_pkg::CMD_GT:     s2_fl_d.cmp = a_s > b_s;
      fpa_pkg::CMD_GE:     s2_fl_d.cmp = a_s >= b_s;
      fpa_pkg::CMD_EQ:     s2_fl_d.cmp = a_s == b_s;
      fpa_pkg::CMD_NE:     s2_fl_d.cmp = a_s != b_s;
      fpa_pkg::CMD_MIN:    s2_r_d = (a_s <= b_s) ? s1_a_q : s1_b_q;
      fpa_pkg::CMD_MAX:    s2_r_d = (a_s >= b_s) ? s1_a_q : s1_b_q;
      fpa_pkg::CMD_TO_INT: s2_r_d = a_s[OPW-1] ? (OPW'(0) - ti) : ti;
      fpa_pkg::CMD_FROM_INT: begin
        s2_fl_d.of = sm[OPW];
        s2_r_d     = sm[OPW-1:0];
      end
      default: s2_r_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_r_q    <= s2_r_d;
      s2_fl_q   <= s2_fl_d;
      s2_mul_q  <= s2_mul_d;
      s2_prod_q <= s2_prod_d;
      s2_d_q    <= s2_d_d;
      s2_rem_q  <= s2_rem_d;
      s2_low_q  <= s2_low_d;
    end
  end

  // ---- stage 3: round and saturate the product ----
  logic                 s3_v_q;
  logic [OPW-1:0]       s3_r_q, s3_r_d;
  fpa_pkg::flags_t      s3_fl_q, s3_fl_d;
  logic [OPW-1:0]       s3_d_q, s3_rem_q, s3_low_q;
  logic                 ds_rdy [DS+1];

  assign en3 = !s3_v_q || ds_rdy[0];

  always_comb begin
    logic             pn;
    logic [2*OPW-1:0] pm;
    logic [MW-1:0]    rm;
    logic [OPW:0]     sm;
    pn = s2_prod_q[2*OPW-1];
    pm = pn ? ((2*OPW)'(0) - s2_prod_q) : s2_prod_q;
    rm = (MW'(pm) + (MW'(1) << (F - 1))) >> F;
    sm = sat_mag(rm, pn);
    s3_r_d  = s2_r_q;
    s3_fl_d = s2_fl_q;
    if (s2_mul_q) begin
      s3_r_d     = sm[OPW-1:0];
      s3_fl_d.of = sm[OPW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_r_q   <= s3_r_d;
      s3_fl_q  <= s3_fl_d;
      s3_d_q   <= s2_d_q;
      s3_rem_q <= s2_rem_q;
      s3_low_q <= s2_low_q;
    end
  end

  // ---- divider stages: two quotient bits each ----
  logic              ds_v   [DS+1];
  logic [OPW-1:0]    ds_r   [DS+1];
  fpa_pkg::flags_t   ds_fl  [DS+1];
  logic [OPW-1:0]    ds_dv  [DS+1];
  logic [OPW-1:0]    ds_rem [DS+1];
  logic [OPW-1:0]    ds_q   [DS+1];
  logic [OPW-1:0]    ds_low [DS+1];
  logic              en_out;

  assign ds_v[0]   = s3_v_q;
  assign ds_r[0]   = s3_r_q;
  assign ds_fl[0]  = s3_fl_q;
  assign ds_dv[0]  = s3_d_q;
  assign ds_rem[0] = s3_rem_q;
  assign ds_q[0]   = '0;
  assign ds_low[0] = s3_low_q;
  assign ds_rdy[DS] = en_out;

  for (genvar k = 0; k < DS; k++) begin : g_div
    fpa_div_stage #(
      .OPW  (OPW),
      .BASE (2 * k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ds_v[k]),
      .ready_o (ds_rdy[k]),
      .valid_o (ds_v[k+1]),
      .ready_i (ds_rdy[k+1]),
      .r_i     (ds_r[k]),
      .fl_i    (ds_fl[k]),
      .d_i     (ds_dv[k]),
      .rem_i   (ds_rem[k]),
      .q_i     (ds_q[k]),
      .low_i   (ds_low[k]),
      .r_o     (ds_r[k+1]),
      .fl_o    (ds_fl[k+1]),
      .d_o     (ds_dv[k+1]),
      .rem_o   (ds_rem[k+1]),
      .q_o     (ds_q[k+1]),
      .low_o   (ds_low[k+1])
    );
  end

  // ---- output stage: round the quotient, saturate, drive the beat ----
  logic                 out_v_q;
  logic [OPW-1:0]       out_r_q, out_r_d;
  logic                 out_cmp_q, out_of_q, out_of_d, out_dz_q;

  assign en_out = !out_v_q || m_axis_tready;

  always_comb begin
    fpa_pkg::flags_t fl;
    logic            rnd;
    logic [OPW:0]    q1, sm;
    fl  = ds_fl[DS];
    // half away from zero: remainder at least half the divisor
    rnd = ds_rem[DS] >= (ds_dv[DS] - ds_rem[DS]);
    q1  = {1'b0, ds_q[DS]} + (OPW+1)'(rnd);
    sm  = sat_mag(MW'(q1), fl.neg);
    out_r_d  = ds_r[DS];
    out_of_d = fl.of;
    if (fl.is_div) begin
      out_of_d = fl.presat || sm[OPW];
      out_r_d  = fl.presat ? (fl.neg ? WMIN_W : WMAX_W) : sm[OPW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= ds_v[DS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_r_q   <= out_r_d;
      out_cmp_q <= ds_fl[DS].cmp;
      out_of_q  <= out_of_d;
      out_dz_q  <= ds_fl[DS].dz;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_dz_q, out_of_q, out_cmp_q,
                          fpa_pkg::FIELD_W'(signed'(out_r_q))};

endmodule
